// ----- sv/sha256md_pkg.sv -----
// Shared types and constants for the SHA-256 message digest block.
package sha256md_pkg;

  // Message item and digest word, one per beat.
  typedef struct packed {
    logic [7:0] message_byte;
    logic       byte_valid;
    logic       last;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  // Source of the byte shifted into the block buffer.
  typedef enum logic [1:0] {
    BSEL_DATA  = 2'd0,
    BSEL_PAD80 = 2'd1,
    BSEL_ZERO  = 2'd2,
    BSEL_LEN   = 2'd3
  } byte_sel_e;

  typedef struct packed {
    logic       shift_en;
    byte_sel_e  byte_sel;
    logic       count_en;
    logic       load_vars;
    logic       round_en;
    logic [5:0] round_idx;
    logic       add_hash;
    logic       init_hash;
    logic [2:0] out_idx;
  } cmd_t;

  typedef struct packed {
    logic [5:0] fill;
  } sts_t;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LEN_FILL  = 6'd56;
  localparam logic [5:0] LAST_FILL = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD_IDX = 3'd7;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

endpackage

// ----- sv/sha256md_dp.sv -----
// Datapath: block buffer, message schedule, round logic, hash state and length counter.
module sha256md_dp #(
  parameter int unsigned LEN_COUNT_BITS = 32
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha256md_pkg::cmd_t  cmd_i,
  input  logic [7:0]          data_byte_i,
  output sha256md_pkg::sts_t  sts_o,
  output logic [31:0]         digest_word_o
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  logic [31:0]               hash_q [8];
  logic [31:0]               vars_q [8];
  logic [31:0]               win_q  [16];
  logic [LEN_COUNT_BITS-1:0] count_q;
  logic [5:0]                fill_q;

  logic [63:0] bit_len;
  logic [63:0] len_shifted;
  logic [7:0]  ins_byte;
  logic [31:0] big_s0, big_s1, ch, maj, t1, t2;
  logic [31:0] sml_s0, sml_s1, sched_new;

  // Message length in bits, big-endian byte picked by position in the length field.
  assign bit_len     = {{(64 - LEN_COUNT_BITS){1'b0}}, count_q} << 3;
  assign len_shifted = bit_len >> {~fill_q[2:0], 3'b000};

  always_comb begin
    case (cmd_i.byte_sel)
      sha256md_pkg::BSEL_DATA:  ins_byte = data_byte_i;
      sha256md_pkg::BSEL_PAD80: ins_byte = sha256md_pkg::PAD_BYTE;
      sha256md_pkg::BSEL_LEN:   ins_byte = len_shifted[7:0];
      default:                  ins_byte = 8'h00;
    endcase
  end

  // One compression round.
  assign big_s1 = rotr(vars_q[4], 6) ^ rotr(vars_q[4], 11) ^ rotr(vars_q[4], 25);
  assign big_s0 = rotr(vars_q[0], 2) ^ rotr(vars_q[0], 13) ^ rotr(vars_q[0], 22);
  assign ch     = (vars_q[4] & vars_q[5]) ^ (~vars_q[4] & vars_q[6]);
  assign maj    = (vars_q[0] & vars_q[1]) ^ (vars_q[0] & vars_q[2]) ^ (vars_q[1] & vars_q[2]);
  assign t1     = vars_q[7] + big_s1 + ch + sha256md_pkg::ROUND_K[cmd_i.round_idx] + win_q[0];
  assign t2     = big_s0 + maj;

  // Rolling schedule: win_q[0] is this round's word, append the word sixteen ahead.
  assign sml_s1    = rotr(win_q[14], 17) ^ rotr(win_q[14], 19) ^ (win_q[14] >> 10);
  assign sml_s0    = rotr(win_q[1], 7) ^ rotr(win_q[1], 18) ^ (win_q[1] >> 3);
  assign sched_new = sml_s1 + win_q[9] + sml_s0 + win_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q  <= sha256md_pkg::H_INIT;
      count_q <= '0;
      fill_q  <= '0;
    end else begin
      if (cmd_i.init_hash) begin
        hash_q <= sha256md_pkg::H_INIT;
      end else if (cmd_i.add_hash) begin
        for (int i = 0; i < 8; i++) begin
          hash_q[i] <= hash_q[i] + vars_q[i];
        end
      end
      if (cmd_i.init_hash) begin
        count_q <= '0;
      end else if (cmd_i.count_en) begin
        count_q <= count_q + LEN_COUNT_BITS'(1);
      end
      if (cmd_i.shift_en) begin
        fill_q <= fill_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_vars) begin
      vars_q <= hash_q;
    end else if (cmd_i.round_en) begin
      vars_q[0] <= t1 + t2;
      vars_q[1] <= vars_q[0];
      vars_q[2] <= vars_q[1];
      vars_q[3] <= vars_q[2];
      vars_q[4] <= vars_q[3] + t1;
      vars_q[5] <= vars_q[4];
      vars_q[6] <= vars_q[5];
      vars_q[7] <= vars_q[6];
    end
  end

  // Shift bytes in as one 512-bit big-endian word; shift schedule words during rounds.
  always_ff @(posedge clk_i) begin
    if (cmd_i.shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[15] <= {win_q[15][23:0], ins_byte};
    end else if (cmd_i.round_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= sched_new;
    end
  end

  assign sts_o.fill    = fill_q;
  assign digest_word_o = hash_q[cmd_i.out_idx];

endmodule

// ----- sv/sha256md_ctrl.sv -----
// Controller: sequences byte intake, padding, compression rounds and digest output.
module sha256md_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  sha256md_pkg::in_beat_t   in_beat_i,
  output logic                     in_stall_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  input  sha256md_pkg::sts_t       sts_i,
  output sha256md_pkg::cmd_t       cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_PAD  = 5'b00010,
    S_COMP = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] idx_q, idx_d;
  logic       pad_q, pad_d;
  logic       fin_q, fin_d;
  logic       first_q, first_d;
  logic       lenph_q, lenph_d;
  logic       is_len;

  assign is_len = !first_q && ((sts_i.fill == sha256md_pkg::LEN_FILL) || lenph_q);

  always_comb begin
    cmd_o          = '0;
    cmd_o.byte_sel = sha256md_pkg::BSEL_DATA;
    cmd_o.round_idx = rnd_q;
    cmd_o.out_idx  = idx_q;
    state_d = state_q;
    rnd_d   = rnd_q;
    idx_d   = idx_q;
    pad_d   = pad_q;
    fin_d   = fin_q;
    first_d = first_q;
    lenph_d = lenph_q;
    case (state_q)
      S_IDLE: begin
        first_d = 1'b1;
        if (in_valid_i) begin
          cmd_o.shift_en = in_beat_i.byte_valid;
          cmd_o.count_en = in_beat_i.byte_valid;
          if (in_beat_i.byte_valid && sts_i.fill == sha256md_pkg::LAST_FILL) begin
            state_d         = S_COMP;
            cmd_o.load_vars = 1'b1;
            rnd_d           = '0;
            pad_d           = in_beat_i.last;
          end else if (in_beat_i.last) begin
            state_d = S_PAD;
            pad_d   = 1'b1;
          end
        end
      end
      S_PAD: begin
        cmd_o.shift_en = 1'b1;
        if (first_q) begin
          cmd_o.byte_sel = sha256md_pkg::BSEL_PAD80;
        end else if (is_len) begin
          cmd_o.byte_sel = sha256md_pkg::BSEL_LEN;
        end else begin
          cmd_o.byte_sel = sha256md_pkg::BSEL_ZERO;
        end
        first_d = 1'b0;
        if (is_len) begin
          lenph_d = 1'b1;
        end
        if (sts_i.fill == sha256md_pkg::LAST_FILL) begin
          state_d         = S_COMP;
          cmd_o.load_vars = 1'b1;
          rnd_d           = '0;
          fin_d           = is_len;
        end
      end
      S_COMP: begin
        cmd_o.round_en = 1'b1;
        rnd_d          = rnd_q + 6'd1;
        if (rnd_q == sha256md_pkg::LAST_ROUND) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.add_hash = 1'b1;
        lenph_d        = 1'b0;
        idx_d          = '0;
        if (fin_q) begin
          state_d = S_OUT;
        end else if (pad_q) begin
          state_d = S_PAD;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_OUT: begin
        if (!out_stall_i) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == sha256md_pkg::LAST_WORD_IDX) begin
            cmd_o.init_hash = 1'b1;
            pad_d           = 1'b0;
            fin_d           = 1'b0;
            state_d         = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rnd_q   <= '0;
      idx_q   <= '0;
      pad_q   <= 1'b0;
      fin_q   <= 1'b0;
      first_q <= 1'b1;
      lenph_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rnd_q   <= rnd_d;
      idx_q   <= idx_d;
      pad_q   <= pad_d;
      fin_q   <= fin_d;
      first_q <= first_d;
      lenph_q <= lenph_d;
    end
  end

endmodule

// ----- sv/sha256_message_digest_top.sv -----
// Top level of the streaming SHA-256 message digest: controller plus datapath.
// A message byte beat is accepted while the block is idle; the 64th byte of a block
// starts its compression (64 rounds of the single round unit, then the hash update).
// On a last beat, padding bytes enter one per cycle (up to 72) except while a full
// block compresses; one or two further blocks compress, then eight digest beats follow.
// Reset loads the initial hash values and clears the byte and fill counters.
module sha256_message_digest_top #(
  parameter int unsigned LEN_COUNT_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  sha256md_pkg::in_beat_t  in_beat_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output sha256md_pkg::out_beat_t out_beat_o
);

  sha256md_pkg::cmd_t cmd;
  sha256md_pkg::sts_t sts;
  logic [31:0]        digest_word;

  // Sequence intake, padding, rounds and digest beats.
  sha256md_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_beat_i   (in_beat_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Hold the block buffer, schedule, working variables and hash words.
  sha256md_dp #(
    .LEN_COUNT_BITS (LEN_COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_beat_i.message_byte),
    .sts_o         (sts),
    .digest_word_o (digest_word)
  );

  // Hash words stay frozen while digest beats drain, so a stalled beat holds.
  assign out_beat_o.digest_word = digest_word;
  assign out_beat_o.word_index  = cmd.out_idx;
  assign out_beat_o.last_word   = (cmd.out_idx == sha256md_pkg::LAST_WORD_IDX);

  // No message beat is taken while a digest drains.
  a_no_intake_during_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while digest beats pending");

  // A digest always starts at word zero.
  a_digest_starts_at_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> (out_beat_o.word_index == 3'd0))
    else $error("digest did not start at word zero");

  // After the final word the output goes quiet and intake resumes.
  a_done_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_beat_o.last_word) |=> (!out_valid_o && !in_stall_o))
    else $error("block did not return to intake after last digest word");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the streaming SHA-256 message digest block.
module testbench;

  // Round constants and initial hash words, kept separate from the design's copy.
  localparam logic [31:0] SHA_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] SHA_IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Well-known digests of the empty message and of "abc".
  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c44298fc1c149afbf4c8996fb92427ae41e4649b934ca495991b7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf8f01cfea414140de5dae2223b00361a396177a9cb410ff61f20015ad;

  // One directed beat; pinned rows carry a digest typed in by hand.
  typedef struct packed {
    sha256md_pkg::in_beat_t beat;
    logic                   pinned;
    logic [255:0]           digest;
  } dir_row_t;

  localparam int DIR_N = 15;
  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    // empty message, byte field zero and then all ones (both ignored)
    '{'{8'h00, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
    '{'{8'hff, 1'b0, 1'b1}, 1'b1, EMPTY_DIGEST},
    // "abc" with the last mark on the final byte
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h63, 1'b1, 1'b1}, 1'b1, ABC_DIGEST},
    // lone beat without data or last: no effect
    '{'{8'ha5, 1'b0, 1'b0}, 1'b0, 256'h0},
    // "abc" again, ignored beat inside, last mark on an empty beat
    '{'{8'h61, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h00, 1'b0, 1'b0}, 1'b0, 256'h0},
    '{'{8'h62, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h63, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h5a, 1'b0, 1'b1}, 1'b1, ABC_DIGEST},
    // byte extremes, checked against the predictor
    '{'{8'hff, 1'b1, 1'b0}, 1'b0, 256'h0},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, 256'h0},
    '{'{8'hff, 1'b1, 1'b1}, 1'b0, 256'h0},
    '{'{8'h00, 1'b1, 1'b1}, 1'b0, 256'h0}
  };

  localparam int unsigned ITEM_TARGET = 130;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 300;
  localparam int unsigned DRAIN_LIMIT = 100000;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  sha256md_pkg::in_beat_t  in_beat_i   = '0;
  logic                    out_stall_i = 1'b0;
  logic                    in_stall_o;
  logic                    out_valid_o;
  sha256md_pkg::out_beat_t out_beat_o;

  sha256_message_digest_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_beat_i  (in_beat_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_beat_o (out_beat_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hash model state: chaining words, partial block, fill and byte count.
  logic [31:0] chain_h [8] = SHA_IV;
  logic [7:0]  block_buf [64];
  int unsigned block_len = 0;
  logic [31:0] msg_bytes = '0;

  sha256md_pkg::out_beat_t digest_q [$];
  int unsigned mismatch_cnt = 0;
  int unsigned msg_no = 0;
  int unsigned item_cnt = 0;
  bit          calm = 1'b0;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic void compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) begin
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = s1 + w[t-7] + s0 + w[t-16];
    end
    v = chain_h;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[t] + w[t];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6];
      v[6] = v[5];
      v[5] = v[4];
      v[4] = v[3] + t1;
      v[3] = v[2];
      v[2] = v[1];
      v[1] = v[0];
      v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain_h[i] = chain_h[i] + v[i];
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    block_buf[block_len] = b;
    block_len++;
    if (block_len == 64) begin
      compress_block();
      block_len = 0;
    end
  endfunction

  // Advance the hash model by one beat; return 1 and the digest on a last beat.
  function automatic bit hash_beat(input sha256md_pkg::in_beat_t b,
                                   output logic [255:0] dig);
    logic [63:0] bit_len;
    dig = '0;
    if (b.byte_valid) begin
      absorb_byte(b.message_byte);
      msg_bytes++;
    end
    if (!b.last) return 1'b0;
    bit_len = {32'b0, msg_bytes} << 3;
    // pad byte, zeros up to the length slot (spilling into a new block if
    // needed), then the 64-bit big-endian bit count
    absorb_byte(sha256md_pkg::PAD_BYTE);
    while (block_len != 56) absorb_byte(8'h00);
    for (int i = 0; i < 8; i++) absorb_byte(bit_len[63 - 8*i -: 8]);
    for (int i = 0; i < 8; i++) dig[255 - 32*i -: 32] = chain_h[i];
    chain_h   = SHA_IV;
    msg_bytes = '0;
    block_len = 0;
    return 1'b1;
  endfunction

  // Offer one beat: random idle cycles first, then hold it until accepted.
  // Each time step sees at most one update of in_valid_i.
  task automatic offer(input sha256md_pkg::in_beat_t b, input bit pinned,
                       input logic [255:0] known);
    logic [255:0]            dig;
    sha256md_pkg::out_beat_t word;
    while (!calm && $urandom_range(99) < 30) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    item_cnt++;
    if (hash_beat(b, dig)) begin
      if (pinned) dig = known;
      for (int i = 0; i < 8; i++) begin
        word.digest_word = dig[255 - 32*i -: 32];
        word.word_index  = 3'(i);
        word.last_word   = (3'(i) == sha256md_pkg::LAST_WORD_IDX);
        digest_q.push_back(word);
      end
    end
  endtask

  // Random message: bytes with random content, stray no-op beats sprinkled in,
  // and the last mark either on the final byte or on an extra empty beat.
  task automatic send_message(input int unsigned len);
    sha256md_pkg::in_beat_t b;
    bit                     mark_on_byte;
    mark_on_byte = (len != 0) && ($urandom_range(1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        b.message_byte = 8'($urandom);
        b.byte_valid   = 1'b0;
        b.last         = 1'b0;
        offer(b, 1'b0, '0);
      end
      b.message_byte = 8'($urandom);
      b.byte_valid   = 1'b1;
      b.last         = mark_on_byte && (i == len - 1);
      offer(b, 1'b0, '0);
    end
    if (!mark_on_byte) begin
      b.message_byte = 8'($urandom);
      b.byte_valid   = 1'b0;
      b.last         = 1'b1;
      offer(b, 1'b0, '0);
    end
  endtask

  // Stimulus: reset, directed table, then random messages.
  initial begin
    int unsigned len;
    int unsigned guard;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_N; r++) begin
      offer(DIR_ROWS[r].beat, DIR_ROWS[r].pinned, DIR_ROWS[r].digest);
    end

    // The first random message holds 56 bytes when padding starts, which forces
    // an extra block; it runs with no idling on either side.
    while (item_cnt < ITEM_TARGET || msg_no < 2) begin
      case (msg_no)
        0: len = 56;
        default: begin
          if (item_cnt + 40 < ITEM_TARGET && $urandom_range(7) == 0) begin
            len = $urandom_range(70, 52);
          end else begin
            len = $urandom_range(20, 0);
          end
        end
      endcase
      calm = (msg_no == 0);
      send_message(len);
      msg_no++;
    end
    calm = 1'b0;
    in_valid_i <= 1'b0;

    // Drain, then give the block time to emit anything unexpected.
    guard = 0;
    while (digest_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (digest_q.size() != 0) begin
      $error("%0d digest words never arrived", digest_q.size());
      mismatch_cnt += digest_q.size();
    end
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Receiver: check each accepted beat, then pick the next stall value.
  // Once, while the block is emitting digest words, hold off for a long
  // stretch so the block backs up and stalls its input.
  initial begin
    sha256md_pkg::out_beat_t want;
    int unsigned             hold_left;
    bit                      squeezed;
    hold_left = 0;
    squeezed  = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (digest_q.size() == 0) begin
          $error("digest beat with nothing expected: %h", out_beat_o);
          mismatch_cnt++;
        end else begin
          want = digest_q.pop_front();
          if (out_beat_o.digest_word !== want.digest_word) begin
            $error("digest_word: expected %h, got %h", want.digest_word,
                   out_beat_o.digest_word);
            mismatch_cnt++;
          end
          if (out_beat_o.word_index !== want.word_index) begin
            $error("word_index: expected %0d, got %0d", want.word_index,
                   out_beat_o.word_index);
            mismatch_cnt++;
          end
          if (out_beat_o.last_word !== want.last_word) begin
            $error("last_word: expected %b, got %b", want.last_word,
                   out_beat_o.last_word);
            mismatch_cnt++;
          end
        end
      end
      if (!squeezed && msg_no >= 2 && out_valid_o) begin
        squeezed  = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(99) < 30) begin
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #4_000_000;
    $error("run did not finish in time");
    $display("Mismatches found");
    $finish;
  end

endmodule
